// ----- hdl/pmsfp_pkg.sv -----
package pmsfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RSUM_W  = 13;

  localparam logic [WORD_W-1:0] MARKER_WORD = 16'h4D42;
  localparam logic [WORD_W-1:0] LOW_BYTE_MASK = 16'h00FF;
  localparam logic [BYTE_W-1:0] MARK_FIRST = BYTE_W'(MARKER_WORD & LOW_BYTE_MASK);
  localparam logic [BYTE_W-1:0] MARK_SECOND =
    BYTE_W'((MARKER_WORD >> BYTE_W) & LOW_BYTE_MASK);
  localparam logic [RSUM_W-1:0] RSUM_INIT =
    RSUM_W'({5'd0, MARK_FIRST}) + RSUM_W'({5'd0, MARK_SECOND});

  // body byte positions of the big-endian PM words
  localparam int unsigned PM1_HI_IDX  = 3;
  localparam int unsigned PM1_LO_IDX  = 4;
  localparam int unsigned PM25_HI_IDX = 5;
  localparam int unsigned PM25_LO_IDX = 6;
  localparam int unsigned PM10_HI_IDX = 7;
  localparam int unsigned PM10_LO_IDX = 8;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic              done;
    logic              good;
    logic [WORD_W-1:0] pm1;
    logic [WORD_W-1:0] pm25;
    logic [WORD_W-1:0] pm10;
  } frame_t;

endpackage

// ----- hdl/pmsfp_framer.sv -----
module pmsfp_framer #(
  parameter int unsigned BODY_LEN = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [pmsfp_pkg::BYTE_W-1:0]  rx_byte,
  output pmsfp_pkg::frame_t             frm
);

  localparam int unsigned IDX_W = $clog2(BODY_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LEN - 1);
  localparam logic [IDX_W-1:0] CHK_HI_IDX = IDX_W'(BODY_LEN - 2);

  pmsfp_pkg::phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [pmsfp_pkg::RSUM_W-1:0] rsum_r, rsum_nxt;
  logic [pmsfp_pkg::BYTE_W-1:0] chk_hi_r, chk_hi_nxt;
  logic [pmsfp_pkg::WORD_W-1:0] pm1_r, pm1_nxt;
  logic [pmsfp_pkg::WORD_W-1:0] pm25_r, pm25_nxt;
  logic [pmsfp_pkg::WORD_W-1:0] pm10_r, pm10_nxt;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        pmsfp_pkg::PH_SECOND: begin
          if (rx_byte == pmsfp_pkg::MARK_SECOND) begin
            phase_nxt = pmsfp_pkg::PH_BODY;
          end else if (rx_byte == pmsfp_pkg::MARK_FIRST) begin
            phase_nxt = pmsfp_pkg::PH_SECOND;
          end else begin
            phase_nxt = pmsfp_pkg::PH_HUNT;
          end
        end
        pmsfp_pkg::PH_BODY: begin
          phase_nxt = (idx_r == LAST_IDX) ? pmsfp_pkg::PH_HUNT : pmsfp_pkg::PH_BODY;
        end
        default: begin
          phase_nxt = (rx_byte == pmsfp_pkg::MARK_FIRST) ?
                      pmsfp_pkg::PH_SECOND : pmsfp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    rsum_nxt   = rsum_r;
    chk_hi_nxt = chk_hi_r;
    pm1_nxt    = pm1_r;
    pm25_nxt   = pm25_r;
    pm10_nxt   = pm10_r;
    case (phase_r)
      pmsfp_pkg::PH_SECOND: begin
        if (step && rx_byte == pmsfp_pkg::MARK_SECOND) begin
          idx_nxt  = '0;
          rsum_nxt = pmsfp_pkg::RSUM_INIT;
        end
      end
      pmsfp_pkg::PH_BODY: begin
        if (step) begin
          case (idx_r)
            IDX_W'(pmsfp_pkg::PM1_HI_IDX):  pm1_nxt[15:8]  = rx_byte;
            IDX_W'(pmsfp_pkg::PM1_LO_IDX):  pm1_nxt[7:0]   = rx_byte;
            IDX_W'(pmsfp_pkg::PM25_HI_IDX): pm25_nxt[15:8] = rx_byte;
            IDX_W'(pmsfp_pkg::PM25_LO_IDX): pm25_nxt[7:0]  = rx_byte;
            IDX_W'(pmsfp_pkg::PM10_HI_IDX): pm10_nxt[15:8] = rx_byte;
            IDX_W'(pmsfp_pkg::PM10_LO_IDX): pm10_nxt[7:0]  = rx_byte;
            default: ;
          endcase
          if (idx_r < CHK_HI_IDX) begin
            rsum_nxt = rsum_r + pmsfp_pkg::RSUM_W'(rx_byte);
          end
          if (idx_r == CHK_HI_IDX) begin
            chk_hi_nxt = rx_byte;
          end
          idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign frm.done = (phase_r == pmsfp_pkg::PH_BODY) && (idx_r == LAST_IDX);
  // last body byte is past the value bytes, so the held words are final here
  assign frm.good = ({{(pmsfp_pkg::WORD_W - pmsfp_pkg::RSUM_W){1'b0}}, rsum_r} ==
                     {chk_hi_r, rx_byte});
  assign frm.pm1  = pm1_r;
  assign frm.pm25 = pm25_r;
  assign frm.pm10 = pm10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= pmsfp_pkg::PH_HUNT;
      idx_r    <= '0;
      rsum_r   <= '0;
      chk_hi_r <= '0;
      pm1_r    <= '0;
      pm25_r   <= '0;
      pm10_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      rsum_r   <= rsum_nxt;
      chk_hi_r <= chk_hi_nxt;
      pm1_r    <= pm1_nxt;
      pm25_r   <= pm25_nxt;
      pm10_r   <= pm10_nxt;
    end
  end

endmodule

// ----- hdl/pmsfp_accum.sv -----
module pmsfp_accum #(
  parameter int unsigned SUM_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  logic                           add,
  input  pmsfp_pkg::frame_t              frm,
  output logic [pmsfp_pkg::TOTAL_W-1:0]  pm1_total_nxt,
  output logic [pmsfp_pkg::TOTAL_W-1:0]  pm25_total_nxt,
  output logic [pmsfp_pkg::TOTAL_W-1:0]  pm10_total_nxt,
  output logic [pmsfp_pkg::COUNT_W-1:0]  count_nxt
);

  logic [SUM_BITS-1:0] pm1_r, pm1_nxt;
  logic [SUM_BITS-1:0] pm25_r, pm25_nxt;
  logic [SUM_BITS-1:0] pm10_r, pm10_nxt;
  logic [pmsfp_pkg::COUNT_W-1:0] count_r;
  logic [SUM_BITS:0] pm1_add, pm25_add, pm10_add;
  logic [SUM_BITS+pmsfp_pkg::TOTAL_W-1:0] pm1_ext, pm25_ext, pm10_ext;
  logic acc_en;

  assign acc_en = add && frm.good;

  assign pm1_add  = {1'b0, pm1_r}  + (SUM_BITS+1)'(frm.pm1);
  assign pm25_add = {1'b0, pm25_r} + (SUM_BITS+1)'(frm.pm25);
  assign pm10_add = {1'b0, pm10_r} + (SUM_BITS+1)'(frm.pm10);

  always_comb begin
    pm1_nxt   = pm1_r;
    pm25_nxt  = pm25_r;
    pm10_nxt  = pm10_r;
    count_nxt = count_r;
    if (clear) begin
      pm1_nxt   = '0;
      pm25_nxt  = '0;
      pm10_nxt  = '0;
      count_nxt = '0;
    end else if (acc_en) begin
      // saturate on carry out
      pm1_nxt  = pm1_add[SUM_BITS]  ? '1 : pm1_add[SUM_BITS-1:0];
      pm25_nxt = pm25_add[SUM_BITS] ? '1 : pm25_add[SUM_BITS-1:0];
      pm10_nxt = pm10_add[SUM_BITS] ? '1 : pm10_add[SUM_BITS-1:0];
      if (count_r != '1) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign pm1_ext  = {{pmsfp_pkg::TOTAL_W{1'b0}}, pm1_nxt};
  assign pm25_ext = {{pmsfp_pkg::TOTAL_W{1'b0}}, pm25_nxt};
  assign pm10_ext = {{pmsfp_pkg::TOTAL_W{1'b0}}, pm10_nxt};
  assign pm1_total_nxt  = pm1_ext[pmsfp_pkg::TOTAL_W-1:0];
  assign pm25_total_nxt = pm25_ext[pmsfp_pkg::TOTAL_W-1:0];
  assign pm10_total_nxt = pm10_ext[pmsfp_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm1_r   <= '0;
      pm25_r  <= '0;
      pm10_r  <= '0;
      count_r <= '0;
    end else begin
      pm1_r   <= pm1_nxt;
      pm25_r  <= pm25_nxt;
      pm10_r  <= pm10_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/pm_sensor_frame_parser.sv -----
// Particulate sensor frame parser.
// Input channel (in_valid/in_ready): one request per beat. A byte request
// (in_req_type = 0) feeds in_rx_byte to the frame hunter; a clear request
// (in_req_type = 1) zeroes the PM sums and the good-frame count and yields
// no result.
// Result channel (out_valid/out_ready): one result per completed frame, on
// the last body byte, with the checksum flag, the three PM words and the
// totals and count after that frame.
// Path: a request lands in the input register at its accepting edge and,
// if it completes a frame, its result is loaded into the output register
// once that register is free; out_valid rises as the output register loads.
// Throughput: one request per cycle while in_ready stays high; the input
// register and the output register each hold one request.
// Stall: while out_valid is held by a low out_ready, the input register
// still drains requests that give no result; a request that completes a
// frame waits in it and in_ready drops until the output register frees up.
// Reset (rst_n low, synchronous): hunting for the first marker, sums and
// count zero, both registers empty.
module pm_sensor_frame_parser #(
  parameter int unsigned BODY_LEN = 22,
  parameter int unsigned SUM_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [pmsfp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_good,
  output logic [pmsfp_pkg::WORD_W-1:0]  out_pm1_value,
  output logic [pmsfp_pkg::WORD_W-1:0]  out_pm25_value,
  output logic [pmsfp_pkg::WORD_W-1:0]  out_pm10_value,
  output logic [pmsfp_pkg::TOTAL_W-1:0] out_pm1_total,
  output logic [pmsfp_pkg::TOTAL_W-1:0] out_pm25_total,
  output logic [pmsfp_pkg::TOTAL_W-1:0] out_pm10_total,
  output logic [pmsfp_pkg::COUNT_W-1:0] out_good_frames
);

  logic s1_valid_r, s1_valid_nxt;
  logic s1_req_r;
  logic [pmsfp_pkg::BYTE_W-1:0] s1_byte_r;
  logic out_valid_r, out_valid_nxt;
  logic out_good_r;
  logic [pmsfp_pkg::WORD_W-1:0] out_pm1_r, out_pm25_r, out_pm10_r;
  logic [pmsfp_pkg::TOTAL_W-1:0] out_pm1_tot_r, out_pm25_tot_r, out_pm10_tot_r;
  logic [pmsfp_pkg::COUNT_W-1:0] out_count_r;

  pmsfp_pkg::frame_t frm;
  logic [pmsfp_pkg::TOTAL_W-1:0] pm1_total_nxt, pm25_total_nxt, pm10_total_nxt;
  logic [pmsfp_pkg::COUNT_W-1:0] count_nxt;

  logic is_byte, frame_end, out_free, advance, out_load;

  assign is_byte   = (s1_req_r == pmsfp_pkg::REQ_BYTE);
  assign frame_end = is_byte && frm.done;
  assign out_free  = !out_valid_r || out_ready;
  // hold a frame-completing request until the output register can take it
  assign advance   = s1_valid_r && (!frame_end || out_free);
  assign out_load  = advance && frame_end;
  assign in_ready  = !s1_valid_r || advance;

  pmsfp_framer #(
    .BODY_LEN (BODY_LEN)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance && is_byte),
    .rx_byte (s1_byte_r),
    .frm     (frm)
  );

  pmsfp_accum #(
    .SUM_BITS (SUM_BITS)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .clear          (advance && (s1_req_r == pmsfp_pkg::REQ_CLEAR)),
    .add            (out_load),
    .frm            (frm),
    .pm1_total_nxt  (pm1_total_nxt),
    .pm25_total_nxt (pm25_total_nxt),
    .pm10_total_nxt (pm10_total_nxt),
    .count_nxt      (count_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_rx_byte;
    end
    if (out_load) begin
      out_good_r     <= frm.good;
      out_pm1_r      <= frm.pm1;
      out_pm25_r     <= frm.pm25;
      out_pm10_r     <= frm.pm10;
      out_pm1_tot_r  <= pm1_total_nxt;
      out_pm25_tot_r <= pm25_total_nxt;
      out_pm10_tot_r <= pm10_total_nxt;
      out_count_r    <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_good  = out_good_r;
  assign out_pm1_value   = out_pm1_r;
  assign out_pm25_value  = out_pm25_r;
  assign out_pm10_value  = out_pm10_r;
  assign out_pm1_total   = out_pm1_tot_r;
  assign out_pm25_total  = out_pm25_tot_r;
  assign out_pm10_total  = out_pm10_tot_r;
  assign out_good_frames = out_count_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned TB_BODY_LEN    = 22;
  localparam int unsigned TB_SUM_BITS    = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;

  typedef struct packed {
    logic                         req;
    logic [pmsfp_pkg::BYTE_W-1:0] data;
  } serial_req_t;

  typedef struct packed {
    logic                          good;
    logic [pmsfp_pkg::WORD_W-1:0]  pm1;
    logic [pmsfp_pkg::WORD_W-1:0]  pm25;
    logic [pmsfp_pkg::WORD_W-1:0]  pm10;
    logic [pmsfp_pkg::TOTAL_W-1:0] pm1_total;
    logic [pmsfp_pkg::TOTAL_W-1:0] pm25_total;
    logic [pmsfp_pkg::TOTAL_W-1:0] pm10_total;
    logic [pmsfp_pkg::COUNT_W-1:0] good_frames;
  } pm_frame_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = pmsfp_pkg::REQ_BYTE;
  logic [pmsfp_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_frame_good;
  logic [pmsfp_pkg::WORD_W-1:0] out_pm1_value;
  logic [pmsfp_pkg::WORD_W-1:0] out_pm25_value;
  logic [pmsfp_pkg::WORD_W-1:0] out_pm10_value;
  logic [pmsfp_pkg::TOTAL_W-1:0] out_pm1_total;
  logic [pmsfp_pkg::TOTAL_W-1:0] out_pm25_total;
  logic [pmsfp_pkg::TOTAL_W-1:0] out_pm10_total;
  logic [pmsfp_pkg::COUNT_W-1:0] out_good_frames;

  serial_req_t pending_reqs[$];
  pm_frame_t   frames_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_queued = 0;
  int unsigned reqs_taken = 0;
  int unsigned clears_taken = 0;
  int unsigned frames_seen = 0;
  int unsigned good_seen = 0;
  int unsigned mismatches = 0;

  // parser shadow state
  pmsfp_pkg::phase_t             parse_phase = pmsfp_pkg::PH_HUNT;
  int unsigned                   body_pos = 0;
  logic [pmsfp_pkg::RSUM_W-1:0]  chk_sum = '0;
  logic [pmsfp_pkg::BYTE_W-1:0]  chk_hi = '0;
  logic [pmsfp_pkg::WORD_W-1:0]  pm_words[3] = '{default: '0};
  logic [TB_SUM_BITS-1:0]        pm_sums[3] = '{default: '0};
  logic [pmsfp_pkg::COUNT_W-1:0] good_cnt = '0;

  pm_sensor_frame_parser #(
    .BODY_LEN(TB_BODY_LEN),
    .SUM_BITS(TB_SUM_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_good(out_frame_good),
    .out_pm1_value(out_pm1_value),
    .out_pm25_value(out_pm25_value),
    .out_pm10_value(out_pm10_value),
    .out_pm1_total(out_pm1_total),
    .out_pm25_total(out_pm25_total),
    .out_pm10_total(out_pm10_total),
    .out_good_frames(out_good_frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TB_SUM_BITS-1:0] sat_add(
      input logic [TB_SUM_BITS-1:0] acc,
      input logic [pmsfp_pkg::WORD_W-1:0] val);
    logic [TB_SUM_BITS:0] s;
    s = {1'b0, acc} + (TB_SUM_BITS+1)'(val);
    return s[TB_SUM_BITS] ? '1 : s[TB_SUM_BITS-1:0];
  endfunction

  // Advance the shadow parser by one request; queue a frame when one completes.
  task automatic parse_request(input logic req, input logic [pmsfp_pkg::BYTE_W-1:0] b);
    pm_frame_t   f;
    logic        ok;
    int unsigned w;
    if (req == pmsfp_pkg::REQ_CLEAR) begin
      pm_sums = '{default: '0};
      good_cnt = '0;
      return;
    end
    case (parse_phase)
      pmsfp_pkg::PH_SECOND: begin
        if (b == pmsfp_pkg::MARK_SECOND) begin
          parse_phase = pmsfp_pkg::PH_BODY;
          body_pos = 0;
          chk_sum = pmsfp_pkg::RSUM_INIT;
        end else if (b != pmsfp_pkg::MARK_FIRST) begin
          parse_phase = pmsfp_pkg::PH_HUNT;
        end
      end
      pmsfp_pkg::PH_BODY: begin
        if (body_pos >= pmsfp_pkg::PM1_HI_IDX && body_pos <= pmsfp_pkg::PM10_LO_IDX) begin
          w = (body_pos - pmsfp_pkg::PM1_HI_IDX) / 2;
          if (((body_pos - pmsfp_pkg::PM1_HI_IDX) % 2) == 0) pm_words[w][15:8] = b;
          else pm_words[w][7:0] = b;
        end
        if (body_pos < TB_BODY_LEN - 2) chk_sum = chk_sum + pmsfp_pkg::RSUM_W'(b);
        if (body_pos == TB_BODY_LEN - 2) chk_hi = b;
        if (body_pos < TB_BODY_LEN - 1) begin
          body_pos++;
        end else begin
          parse_phase = pmsfp_pkg::PH_HUNT;
          body_pos = 0;
          ok = (pmsfp_pkg::WORD_W'(chk_sum) == {chk_hi, b});
          if (ok) begin
            for (int i = 0; i < 3; i++) pm_sums[i] = sat_add(pm_sums[i], pm_words[i]);
            if (good_cnt != '1) good_cnt++;
          end
          f.good = ok;
          f.pm1 = pm_words[0];
          f.pm25 = pm_words[1];
          f.pm10 = pm_words[2];
          f.pm1_total = pmsfp_pkg::TOTAL_W'(pm_sums[0]);
          f.pm25_total = pmsfp_pkg::TOTAL_W'(pm_sums[1]);
          f.pm10_total = pmsfp_pkg::TOTAL_W'(pm_sums[2]);
          f.good_frames = good_cnt;
          frames_due.push_back(f);
        end
      end
      default: parse_phase = (b == pmsfp_pkg::MARK_FIRST) ?
                             pmsfp_pkg::PH_SECOND : pmsfp_pkg::PH_HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [pmsfp_pkg::TOTAL_W-1:0] want,
                             input logic [pmsfp_pkg::TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_request(in_req_type, in_rx_byte);
        reqs_taken++;
        if (in_req_type == pmsfp_pkg::REQ_CLEAR) clears_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the offered request
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req_type <= pending_reqs[0].req;
        in_rx_byte <= pending_reqs[0].data;
        pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // frame monitor and receiver back-pressure
  always @(posedge clk) begin : watch_frames
    pm_frame_t f;
    if (rst_n && out_valid && out_ready) begin
      frames_seen++;
      if (out_frame_good === 1'b1) good_seen++;
      if (frames_due.size() == 0) begin
        $error("frame result with none pending");
        mismatches++;
      end else begin
        f = frames_due.pop_front();
        check_field("frame_good", pmsfp_pkg::TOTAL_W'(f.good),
                    pmsfp_pkg::TOTAL_W'(out_frame_good));
        check_field("pm1_value", pmsfp_pkg::TOTAL_W'(f.pm1),
                    pmsfp_pkg::TOTAL_W'(out_pm1_value));
        check_field("pm25_value", pmsfp_pkg::TOTAL_W'(f.pm25),
                    pmsfp_pkg::TOTAL_W'(out_pm25_value));
        check_field("pm10_value", pmsfp_pkg::TOTAL_W'(f.pm10),
                    pmsfp_pkg::TOTAL_W'(out_pm10_value));
        check_field("pm1_total", f.pm1_total, out_pm1_total);
        check_field("pm25_total", f.pm25_total, out_pm25_total);
        check_field("pm10_total", f.pm10_total, out_pm10_total);
        check_field("good_frames", pmsfp_pkg::TOTAL_W'(f.good_frames),
                    pmsfp_pkg::TOTAL_W'(out_good_frames));
      end
    end
    if (recv_hold_left != 0) begin
      recv_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic req, input logic [pmsfp_pkg::BYTE_W-1:0] b);
    serial_req_t r;
    r.req = req;
    r.data = b;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  function automatic logic [pmsfp_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return pmsfp_pkg::WORD_W'($urandom);
    endcase
  endfunction

  // Queue a complete frame: markers, body with the PM words, checksum word.
  task automatic queue_frame(input logic [pmsfp_pkg::WORD_W-1:0] pm1, pm25, pm10,
                             input bit bad_sum, input int extra_first,
                             input bit clear_inside);
    logic [pmsfp_pkg::BYTE_W-1:0] body[TB_BODY_LEN];
    logic [pmsfp_pkg::WORD_W-1:0] ck;
    int                           clr_pos;
    for (int i = 0; i < TB_BODY_LEN; i++) body[i] = pmsfp_pkg::BYTE_W'($urandom);
    {body[pmsfp_pkg::PM1_HI_IDX], body[pmsfp_pkg::PM1_LO_IDX]} = pm1;
    {body[pmsfp_pkg::PM25_HI_IDX], body[pmsfp_pkg::PM25_LO_IDX]} = pm25;
    {body[pmsfp_pkg::PM10_HI_IDX], body[pmsfp_pkg::PM10_LO_IDX]} = pm10;
    ck = pmsfp_pkg::WORD_W'(pmsfp_pkg::RSUM_INIT);
    for (int i = 0; i < TB_BODY_LEN - 2; i++) ck += pmsfp_pkg::WORD_W'(body[i]);
    if (bad_sum) ck ^= pmsfp_pkg::WORD_W'($urandom_range(65535, 1));
    {body[TB_BODY_LEN-2], body[TB_BODY_LEN-1]} = ck;
    clr_pos = clear_inside ? int'($urandom_range(TB_BODY_LEN - 1)) : -1;
    repeat (extra_first + 1) queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_FIRST);
    queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_SECOND);
    for (int i = 0; i < TB_BODY_LEN; i++) begin
      if (i == clr_pos) queue_request(pmsfp_pkg::REQ_CLEAR, pmsfp_pkg::BYTE_W'($urandom));
      queue_request(pmsfp_pkg::REQ_BYTE, body[i]);
    end
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    target = items_queued + n;
    while (items_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        queue_frame(pick_word(), pick_word(), pick_word(), ($urandom_range(3) == 0),
                    ($urandom_range(4) == 0) ? int'($urandom_range(2, 1)) : 0,
                    ($urandom_range(19) == 0));
      end else if (pick < 85) begin
        repeat ($urandom_range(5, 1))
          queue_request(pmsfp_pkg::REQ_BYTE, $urandom_range(1) ?
                        pmsfp_pkg::MARK_FIRST : pmsfp_pkg::BYTE_W'($urandom));
      end else if (pick < 90) begin
        queue_request(pmsfp_pkg::REQ_CLEAR, pmsfp_pkg::BYTE_W'($urandom));
      end else begin
        // broken frame: markers and a truncated body
        queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_FIRST);
        queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_SECOND);
        repeat ($urandom_range(TB_BODY_LEN - 1))
          queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::BYTE_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || frames_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    @(posedge clk);
    @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests
    set_idling(0, 0);
    queue_request(pmsfp_pkg::REQ_BYTE, 8'h00);
    queue_request(pmsfp_pkg::REQ_BYTE, 8'hFF);
    queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_SECOND);
    queue_request(pmsfp_pkg::REQ_BYTE, pmsfp_pkg::MARK_FIRST);
    queue_request(pmsfp_pkg::REQ_BYTE, 8'h00);
    queue_request(pmsfp_pkg::REQ_CLEAR, pmsfp_pkg::MARK_FIRST);
    queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 1'b0);
    queue_frame(16'h0000, 16'h0000, 16'h0000, 1'b0, 0, 1'b0);
    queue_frame(16'h1234, 16'h5678, 16'h9ABC, 1'b1, 0, 1'b0);
    queue_frame(16'h00A5, 16'h5A00, 16'h8001, 1'b0, 2, 1'b0);
    queue_frame(16'h7FFF, 16'h8000, 16'h0001, 1'b0, 0, 1'b1);
    queue_request(pmsfp_pkg::REQ_CLEAR, 8'hFF);
    queue_frame(16'h0102, 16'h0304, 16'h0506, 1'b0, 0, 1'b0);
    wait_drained();

    // long receiver hold-off while requests keep coming
    recv_hold_left = 300;
    repeat (12) queue_frame(pick_word(), pick_word(), pick_word(), 1'b0, 0, 1'b0);
    wait_drained();

    set_idling(0, 0);
    random_traffic(420);
    wait_drained();
    set_idling(69, 0);
    random_traffic(420);
    wait_drained();
    set_idling(0, 69);
    random_traffic(420);
    wait_drained();
    set_idling(32, 32);
    random_traffic(420);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d requests (%0d clears) through frame hunting, body capture and checksum",
             reqs_taken, clears_taken);
    $display("Checked %0d frame results, %0d with a good checksum", frames_seen, good_seen);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
